@@ rtl/attitude_stabilizer_pid_mixer_top_assert.svh @@
// Assertion macros for the attitude stabiliser.
// Each macro checks one property on the rising clock edge, with reset masking it.
`ifndef ATTITUDE_STABILIZER_PID_MIXER_TOP_ASSERT_SVH
`define ATTITUDE_STABILIZER_PID_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aspm assertion failed");
// Next-cycle implication.
`define ASPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aspm assertion failed");
`else
`define ASPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/aspm_pkg.sv @@
package aspm_pkg;

  // Number formats and limits.
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int PWM_BITS      = 13;
  localparam int PULSE_MIN     = 1000;
  localparam int PULSE_MAX     = 2000;
  localparam int PWM_PERIOD_US = 20000;
  localparam int GYRO_SCALE    = 131;
  localparam int WEIGHT_ONE    = 65536;

  localparam logic signed [33:0] HALF_TURN_Q24 = 34'sd3019898880;

  // Register indexes.
  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_BLEND  = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;
  localparam logic [2:0] REG_RATE   = 3'd5;
  localparam logic [2:0] REG_ILIM   = 3'd6;
  localparam logic [2:0] REG_FSTEP  = 3'd7;

  // Register values after reset.
  localparam logic [31:0] KP_RESET     = 32'd21810381;
  localparam logic [31:0] KI_RESET     = 32'd5033;
  localparam logic [31:0] KD_RESET     = 32'd5033165;
  localparam logic [16:0] BLEND_RESET  = 17'd64225;
  localparam logic [23:0] PERIOD_RESET = 24'd167772;
  localparam logic [9:0]  RATE_RESET   = 10'd100;
  localparam logic [30:0] ILIM_RESET   = 31'd6553600;
  localparam logic [9:0]  FSTEP_RESET  = 10'd20;

  // CORDIC arc table, atan(2^-i) in degrees Q6.24.
  function automatic logic [29:0] arc_q24(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd754974720;
      5'd1:  r = 30'd445687602;
      5'd2:  r = 30'd235489088;
      5'd3:  r = 30'd119537938;
      5'd4:  r = 30'd60000934;
      5'd5:  r = 30'd30029717;
      5'd6:  r = 30'd15018523;
      5'd7:  r = 30'd7509720;
      5'd8:  r = 30'd3754917;
      5'd9:  r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/attitude_stabilizer_pid_mixer_top.sv @@
// Each request runs 18 serial multiplies, six serial constant divisions, two CORDIC
// runs and a square root, one unit at a time. A new request is taken only once the
// last result is in the output register; every unit retires one bit or step a cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous, active high) loads the register defaults, clears the
// angle and PID state and sets the base throttle to 1000 us.
`include "attitude_stabilizer_pid_mixer_top_assert.svh"

module attitude_stabilizer_pid_mixer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, throttle_value, zero fill
  input  logic [95:0]  s_axis_tdata,
  // throttle_write, link_lost
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // motor1_duty, motor2_duty, motor3_duty, motor4_duty, roll_estimate,
  // pitch_estimate, zero fill
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [4:0] ST_IDLE       = 5'd0;
  localparam logic [4:0] ST_SQ_Y       = 5'd1;
  localparam logic [4:0] ST_SQ_Z       = 5'd2;
  localparam logic [4:0] ST_ROLL_TILT  = 5'd3;
  localparam logic [4:0] ST_SQRT       = 5'd4;
  localparam logic [4:0] ST_PITCH_TILT = 5'd5;
  localparam logic [4:0] ST_G_MUL      = 5'd6;
  localparam logic [4:0] ST_G_DIV      = 5'd7;
  localparam logic [4:0] ST_B_W        = 5'd8;
  localparam logic [4:0] ST_B_NW       = 5'd9;
  localparam logic [4:0] ST_I_MUL      = 5'd10;
  localparam logic [4:0] ST_D_MUL      = 5'd11;
  localparam logic [4:0] ST_P_MUL      = 5'd12;
  localparam logic [4:0] ST_KI_MUL     = 5'd13;
  localparam logic [4:0] ST_KD_MUL     = 5'd14;
  localparam logic [4:0] ST_DUTY       = 5'd15;
  localparam logic [4:0] ST_OUT        = 5'd16;

  // Configuration registers.
  logic [31:0] kp, ki, kd;
  logic [16:0] blend_w;
  logic [23:0] period;
  logic [9:0]  rate;
  logic [30:0] ilim;
  logic [9:0]  fstep;

  // Filter and loop state.
  logic signed [31:0] roll_angle, pitch_angle;
  logic signed [31:0] roll_integ, roll_last, pitch_integ, pitch_last;
  logic [10:0]        base;

  // Sequencer.
  logic [4:0] state;
  logic       launched;
  logic       axis;
  logic [1:0] midx;

  // Captured request and intermediate values.
  logic signed [15:0] ax, ay, az, gx, gy;
  logic [31:0]        sumsq;
  logic [23:0]        mag;
  logic signed [25:0] roll_tilt, pitch_tilt;
  logic signed [39:0] gprod;
  logic signed [32:0] sum_a;
  logic signed [50:0] mix_part;
  logic signed [31:0] der;
  logic signed [43:0] corr_work, roll_fix, pitch_fix;
  logic [12:0]        duty_q [4];
  logic               m_valid;
  logic [119:0]       out_data;

  // Serial multiplier: signed a times unsigned b, one bit of b a cycle.
  logic signed [66:0] mul_a, mul_acc;
  logic [31:0]        mul_b;
  logic [5:0]         mul_cnt;
  logic               mul_busy, mul_done, mul_go;
  logic signed [34:0] mul_a_in;
  logic [31:0]        mul_b_in;

  // Serial divider by a constant, one quotient bit a cycle.
  logic [39:0] div_q;
  logic [15:0] div_rem;
  logic [5:0]  div_cnt;
  logic        div_busy, div_done, div_go, div_sel, div_sel_in;
  logic [39:0] div_in;
  logic [15:0] div_den;
  logic [16:0] div_rem_sh;

  // CORDIC vectoring unit, one rotation a cycle.
  logic signed [26:0] cx, cy, cx_in, cy_in, csx, csy;
  logic signed [33:0] cz;
  logic [4:0]         ci;
  logic               cbusy, czero, cor_done, cor_go;
  logic signed [25:0] cres;

  // Square root, one result bit a cycle.
  logic [47:0] sq_n;
  logic [25:0] sq_rem;
  logic [23:0] sq_root;
  logic [4:0]  sq_cnt;
  logic        sq_busy, sq_done, sq_go;
  logic [27:0] sq_rem_sh, sq_trial;

  // Per-state selections.
  logic        use_mul, use_div, use_cor, use_sq, cur_done, go, fin;
  logic [16:0] abs_ay, abs_az, w_eff, w_rest;
  logic signed [16:0] ay_ext, az_ext, nax;
  logic signed [31:0] cur_angle, cur_integ, cur_last;
  logic signed [15:0] cur_gyro;
  logic signed [25:0] cur_acc;
  logic signed [32:0] err_c;
  logic signed [33:0] diff_c;
  logic signed [40:0] q_s;
  logic signed [50:0] mix_sum;
  logic signed [33:0] isum, ilim_s;
  logic signed [43:0] prod_sh, corr_sum;
  logic signed [45:0] base_q, p_term, r_term, pulse, pulse_us;
  logic [10:0]        us;
  logic [10:0]        thr_load, thr_next, thr_val;

  assign ay_ext = 17'(ay);
  assign az_ext = 17'(az);
  assign nax    = -17'(ax);
  assign abs_ay = ay[15] ? 17'(-ay_ext) : 17'(ay_ext);
  assign abs_az = az[15] ? 17'(-az_ext) : 17'(az_ext);
  assign w_eff  = (blend_w > 17'(aspm_pkg::WEIGHT_ONE)) ? 17'(aspm_pkg::WEIGHT_ONE) : blend_w;
  assign w_rest = 17'(aspm_pkg::WEIGHT_ONE) - w_eff;

  assign cur_angle = axis ? pitch_angle : roll_angle;
  assign cur_integ = axis ? pitch_integ : roll_integ;
  assign cur_last  = axis ? pitch_last : roll_last;
  assign cur_gyro  = axis ? gy : gx;
  assign cur_acc   = axis ? pitch_tilt : roll_tilt;
  assign err_c     = -33'(cur_angle);
  assign diff_c    = 34'(err_c) - 34'(cur_last);

  // Throttle load and failsafe descent at the request.
  assign thr_val  = s_axis_tdata[90:80];
  assign thr_load = s_axis_tuser[0]
                  ? ((thr_val > 11'(aspm_pkg::PULSE_MAX)) ? 11'(aspm_pkg::PULSE_MAX) : thr_val)
                  : base;
  always_comb begin
    thr_next = thr_load;
    if (s_axis_tuser[1] && thr_load > 11'(aspm_pkg::PULSE_MIN)) begin
      if (thr_load - 11'(aspm_pkg::PULSE_MIN) > 11'(fstep)) begin
        thr_next = thr_load - 11'(fstep);
      end else begin
        thr_next = 11'(aspm_pkg::PULSE_MIN);
      end
    end
  end

  // Mixer pulse for the motor in hand, clamped to the legal pulse range.
  assign base_q   = $signed(46'({base, 16'b0}));
  assign p_term   = (midx == 2'd1 || midx == 2'd2) ? -46'(pitch_fix) : 46'(pitch_fix);
  assign r_term   = (midx == 2'd2 || midx == 2'd3) ? -46'(roll_fix) : 46'(roll_fix);
  assign pulse    = base_q + p_term + r_term;
  assign pulse_us = pulse >>> aspm_pkg::FRAC_BITS;
  always_comb begin
    if (pulse_us < 46'sd1000) begin
      us = 11'(aspm_pkg::PULSE_MIN);
    end else if (pulse_us > 46'sd2000) begin
      us = 11'(aspm_pkg::PULSE_MAX);
    end else begin
      us = pulse_us[10:0];
    end
  end

  // Results of the finishing step.
  assign q_s      = gprod[39] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign mix_sum  = mix_part + 51'(mul_acc);
  assign prod_sh  = 44'(mul_acc >>> 24);
  assign corr_sum = corr_work + prod_sh;
  assign ilim_s   = $signed({3'b0, ilim});
  assign isum     = 34'(cur_integ) + 34'(mul_acc >>> 24);

  // Operand and unit selection for each step.
  always_comb begin
    use_mul    = 1'b0;
    use_div    = 1'b0;
    use_cor    = 1'b0;
    use_sq     = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_in     = '0;
    div_sel_in = 1'b0;
    cx_in      = '0;
    cy_in      = '0;
    unique case (state)
      ST_SQ_Y: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(abs_ay);
        mul_b_in = 32'(abs_ay);
      end
      ST_SQ_Z: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(abs_az);
        mul_b_in = 32'(abs_az);
      end
      ST_ROLL_TILT: begin
        use_cor = 1'b1;
        cy_in   = {{3{ay[15]}}, ay, 8'b0};
        cx_in   = {{3{az[15]}}, az, 8'b0};
      end
      ST_SQRT: begin
        use_sq = 1'b1;
      end
      ST_PITCH_TILT: begin
        use_cor = 1'b1;
        cy_in   = {{2{nax[16]}}, nax, 8'b0};
        cx_in   = $signed({3'b0, mag});
      end
      ST_G_MUL: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(cur_gyro);
        mul_b_in = 32'(period);
      end
      ST_G_DIV: begin
        use_div = 1'b1;
        div_in  = gprod[39] ? 40'(-gprod) : 40'(gprod);
      end
      ST_B_W: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(sum_a);
        mul_b_in = 32'(w_eff);
      end
      ST_B_NW: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(cur_acc);
        mul_b_in = 32'(w_rest);
      end
      ST_I_MUL: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(err_c);
        mul_b_in = 32'(period);
      end
      ST_D_MUL: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(diff_c);
        mul_b_in = 32'(rate);
      end
      ST_P_MUL: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(err_c);
        mul_b_in = kp;
      end
      ST_KI_MUL: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(cur_integ);
        mul_b_in = ki;
      end
      ST_KD_MUL: begin
        use_mul  = 1'b1;
        mul_a_in = 35'(der);
        mul_b_in = kd;
      end
      ST_DUTY: begin
        use_div    = 1'b1;
        div_sel_in = 1'b1;
        div_in     = 40'(us) << aspm_pkg::PWM_BITS;
      end
      default: begin
        use_mul = 1'b0;
      end
    endcase
  end

  assign cur_done = (use_mul & mul_done) | (use_div & div_done) | (use_cor & cor_done)
                  | (use_sq & sq_done);
  assign go     = !launched && (use_mul || use_div || use_cor || use_sq);
  assign fin    = launched && cur_done;
  assign mul_go = go && use_mul;
  assign div_go = go && use_div;
  assign cor_go = go && use_cor;
  assign sq_go  = go && use_sq;

  // Serial multiplier.
  assign mul_done = mul_busy && mul_cnt == 6'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_cnt  <= '0;
    end else if (mul_go) begin
      mul_a    <= 67'(mul_a_in);
      mul_b    <= mul_b_in;
      mul_acc  <= '0;
      mul_cnt  <= 6'd32;
      mul_busy <= 1'b1;
    end else if (mul_done) begin
      mul_busy <= 1'b0;
    end else if (mul_busy) begin
      if (mul_b[0]) begin
        mul_acc <= mul_acc + mul_a;
      end
      mul_a   <= mul_a <<< 1;
      mul_b   <= mul_b >> 1;
      mul_cnt <= mul_cnt - 6'd1;
    end
  end

  // Restoring divider by 131 or by the PWM period.
  assign div_done   = div_busy && div_cnt == 6'd0;
  assign div_den    = div_sel ? 16'(aspm_pkg::PWM_PERIOD_US) : 16'(aspm_pkg::GYRO_SCALE);
  assign div_rem_sh = {div_rem, div_q[39]};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_go) begin
      div_q    <= div_in;
      div_rem  <= '0;
      div_sel  <= div_sel_in;
      div_cnt  <= 6'd40;
      div_busy <= 1'b1;
    end else if (div_done) begin
      div_busy <= 1'b0;
    end else if (div_busy) begin
      if (div_rem_sh >= {1'b0, div_den}) begin
        div_rem <= 16'(div_rem_sh - {1'b0, div_den});
        div_q   <= {div_q[38:0], 1'b1};
      end else begin
        div_rem <= div_rem_sh[15:0];
        div_q   <= {div_q[38:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
    end
  end

  // CORDIC vectoring; a negative x is first turned by half a circle.
  assign cor_done = cbusy && ci == 5'(aspm_pkg::CORDIC_STEPS);
  assign csx      = cx >>> ci;
  assign csy      = cy >>> ci;
  assign cres     = czero ? 26'sd0 : 26'(cz >>> (24 - aspm_pkg::FRAC_BITS));
  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      ci    <= '0;
    end else if (cor_go) begin
      czero <= (cx_in == 27'sd0) && (cy_in == 27'sd0);
      if (cx_in < 27'sd0) begin
        cz <= (cy_in >= 27'sd0) ? aspm_pkg::HALF_TURN_Q24 : -aspm_pkg::HALF_TURN_Q24;
        cx <= -cx_in;
        cy <= -cy_in;
      end else begin
        cz <= '0;
        cx <= cx_in;
        cy <= cy_in;
      end
      ci    <= '0;
      cbusy <= 1'b1;
    end else if (cor_done) begin
      cbusy <= 1'b0;
    end else if (cbusy) begin
      if (!cy[26]) begin
        cx <= cx + csy;
        cy <= cy - csx;
        cz <= cz + $signed({4'b0, aspm_pkg::arc_q24(ci)});
      end else begin
        cx <= cx - csy;
        cy <= cy + csx;
        cz <= cz - $signed({4'b0, aspm_pkg::arc_q24(ci)});
      end
      ci <= ci + 5'd1;
    end
  end

  // Digit-by-digit square root of the scaled squared magnitude.
  assign sq_done   = sq_busy && sq_cnt == 5'd0;
  assign sq_rem_sh = {sq_rem, sq_n[47:46]};
  assign sq_trial  = {2'b0, sq_root, 2'b01};
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_cnt  <= '0;
    end else if (sq_go) begin
      sq_n    <= {sumsq, 16'b0};
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= 5'd24;
      sq_busy <= 1'b1;
    end else if (sq_done) begin
      sq_busy <= 1'b0;
    end else if (sq_busy) begin
      if (sq_rem_sh >= sq_trial) begin
        sq_rem  <= 26'(sq_rem_sh - sq_trial);
        sq_root <= {sq_root[22:0], 1'b1};
      end else begin
        sq_rem  <= sq_rem_sh[25:0];
        sq_root <= {sq_root[22:0], 1'b0};
      end
      sq_n   <= sq_n << 2;
      sq_cnt <= sq_cnt - 5'd1;
    end
  end

  // Configuration, sequencer and state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= aspm_pkg::KP_RESET;
      ki          <= aspm_pkg::KI_RESET;
      kd          <= aspm_pkg::KD_RESET;
      blend_w     <= aspm_pkg::BLEND_RESET;
      period      <= aspm_pkg::PERIOD_RESET;
      rate        <= aspm_pkg::RATE_RESET;
      ilim        <= aspm_pkg::ILIM_RESET;
      fstep       <= aspm_pkg::FSTEP_RESET;
      roll_angle  <= '0;
      pitch_angle <= '0;
      roll_integ  <= '0;
      roll_last   <= '0;
      pitch_integ <= '0;
      pitch_last  <= '0;
      base        <= 11'(aspm_pkg::PULSE_MIN);
      state       <= ST_IDLE;
      launched    <= 1'b0;
      axis        <= 1'b0;
      midx        <= '0;
      m_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          aspm_pkg::REG_KP:     kp      <= cfg_wdata;
          aspm_pkg::REG_KI:     ki      <= cfg_wdata;
          aspm_pkg::REG_KD:     kd      <= cfg_wdata;
          aspm_pkg::REG_BLEND:  blend_w <= cfg_wdata[16:0];
          aspm_pkg::REG_PERIOD: period  <= cfg_wdata[23:0];
          aspm_pkg::REG_RATE:   rate    <= cfg_wdata[9:0];
          aspm_pkg::REG_ILIM:   ilim    <= cfg_wdata[30:0];
          aspm_pkg::REG_FSTEP:  fstep   <= cfg_wdata[9:0];
        endcase
      end

      if (go) begin
        launched <= 1'b1;
      end else if (fin) begin
        launched <= 1'b0;
      end

      // Output register: filled at hand-over, emptied when the receiver takes it.
      if (state == ST_OUT && (!m_valid || m_axis_tready)) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ax    <= s_axis_tdata[15:0];
            ay    <= s_axis_tdata[31:16];
            az    <= s_axis_tdata[47:32];
            gx    <= s_axis_tdata[63:48];
            gy    <= s_axis_tdata[79:64];
            base  <= thr_next;
            axis  <= 1'b0;
            state <= ST_SQ_Y;
          end
        end
        ST_SQ_Y: begin
          if (fin) begin
            sumsq <= mul_acc[31:0];
            state <= ST_SQ_Z;
          end
        end
        ST_SQ_Z: begin
          if (fin) begin
            sumsq <= sumsq + mul_acc[31:0];
            state <= ST_ROLL_TILT;
          end
        end
        ST_ROLL_TILT: begin
          if (fin) begin
            roll_tilt <= cres;
            state     <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (fin) begin
            mag   <= sq_root;
            state <= ST_PITCH_TILT;
          end
        end
        ST_PITCH_TILT: begin
          if (fin) begin
            pitch_tilt <= cres;
            state      <= ST_G_MUL;
          end
        end
        ST_G_MUL: begin
          if (fin) begin
            gprod <= mul_acc[39:0];
            state <= ST_G_DIV;
          end
        end
        ST_G_DIV: begin
          // Gyro step truncated towards zero, then floored to the angle format.
          if (fin) begin
            sum_a <= 33'(cur_angle) + 33'(q_s >>> (24 - aspm_pkg::FRAC_BITS));
            state <= ST_B_W;
          end
        end
        ST_B_W: begin
          if (fin) begin
            mix_part <= mul_acc[50:0];
            state    <= ST_B_NW;
          end
        end
        ST_B_NW: begin
          if (fin) begin
            if (axis) begin
              pitch_angle <= aspm_pkg::sat32(mix_sum >>> 16);
              axis        <= 1'b0;
              state       <= ST_I_MUL;
            end else begin
              roll_angle <= aspm_pkg::sat32(mix_sum >>> 16);
              axis       <= 1'b1;
              state      <= ST_G_MUL;
            end
          end
        end
        ST_I_MUL: begin
          // Integral with a symmetric clamp.
          if (fin) begin
            if (isum > ilim_s) begin
              if (axis) pitch_integ <= 32'(ilim_s);
              else roll_integ <= 32'(ilim_s);
            end else if (isum < -ilim_s) begin
              if (axis) pitch_integ <= 32'(-ilim_s);
              else roll_integ <= 32'(-ilim_s);
            end else begin
              if (axis) pitch_integ <= 32'(isum);
              else roll_integ <= 32'(isum);
            end
            state <= ST_D_MUL;
          end
        end
        ST_D_MUL: begin
          if (fin) begin
            if (mul_acc > 67'sd2147483647) begin
              der <= 32'sh7FFFFFFF;
            end else if (mul_acc < -67'sd2147483647) begin
              der <= -32'sh7FFFFFFF;
            end else begin
              der <= mul_acc[31:0];
            end
            if (axis) pitch_last <= aspm_pkg::sat32(51'(err_c));
            else roll_last <= aspm_pkg::sat32(51'(err_c));
            state <= ST_P_MUL;
          end
        end
        ST_P_MUL: begin
          if (fin) begin
            corr_work <= prod_sh;
            state     <= ST_KI_MUL;
          end
        end
        ST_KI_MUL: begin
          if (fin) begin
            corr_work <= corr_sum;
            state     <= ST_KD_MUL;
          end
        end
        ST_KD_MUL: begin
          if (fin) begin
            if (axis) begin
              pitch_fix <= corr_sum;
              axis      <= 1'b0;
              midx      <= '0;
              state     <= ST_DUTY;
            end else begin
              roll_fix <= corr_sum;
              axis     <= 1'b1;
              state    <= ST_I_MUL;
            end
          end
        end
        ST_DUTY: begin
          if (fin) begin
            duty_q[midx] <= div_q[12:0];
            midx         <= midx + 2'd1;
            if (midx == 2'd3) begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          // Hand over once the output register is free or being emptied.
          if (!m_valid || m_axis_tready) begin
            out_data <= {4'b0, pitch_angle, roll_angle,
                         duty_q[3], duty_q[2], duty_q[1], duty_q[0]};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = out_data;

  // Only one arithmetic unit runs at a time.
  `ASPM_ASSERT_IMPLY(a_one_unit, clk, rst, 1'b1, $onehot0({mul_busy, div_busy, cbusy, sq_busy}))
  // Base throttle never rises above the pulse ceiling.
  `ASPM_ASSERT_IMPLY(a_base_range, clk, rst, 1'b1, base <= 11'(aspm_pkg::PULSE_MAX))
  // An accepted request starts the sequence.
  `ASPM_ASSERT_NEXT(a_accept_starts, clk, rst, s_axis_tvalid && s_axis_tready, state == ST_SQ_Y)

endmodule
